// ----- design/psem_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psem_pkg
// Shared constants, codes and controller/datapath signal groups for the
// priority wait counting semaphore.
// ----------------------------------------------------------------------------
package psem_pkg;

    // sizing
    localparam int MAX_WAITERS = 8;
    localparam int COUNT_BITS  = 16;
    localparam int TASK_W      = 8;
    localparam int PRIO_W      = 8;
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 3;
    localparam int WAIT_CNT_W  = $clog2(MAX_WAITERS + 1);
    localparam int IDX_W       = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
    localparam int CFG_IDX_W   = 1;

    // commands
    localparam logic [CMD_W-1:0] CMD_TAKE   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_GIVE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_GRANTED     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BLOCKED     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_WOULD_BLOCK = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL        = 3'd3;
    localparam logic [STATUS_W-1:0] ST_HANDED_OFF  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_REMOVED     = 3'd5;
    localparam logic [STATUS_W-1:0] ST_NOT_QUEUED  = 3'd6;
    localparam logic [STATUS_W-1:0] ST_QUEUE_FULL  = 3'd7;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESET = 1'd1;

    // commands from controller to datapath
    typedef struct packed {
        logic                load_in;      // latch the request payload
        logic                count_dec;
        logic                count_inc;
        logic                total_inc;
        logic                total_dec;
        logic                idx_clear;
        logic                idx_one;
        logic                idx_total;
        logic                idx_inc;
        logic                idx_dec;
        logic                rd_below;     // read port addresses idx - 1
        logic                wr_new;       // entry[idx] = request
        logic                wr_up;        // entry[idx] = entry[idx - 1]
        logic                wr_down;      // entry[idx - 1] = entry[idx]
        logic                capture_head; // take head waiter as woken task
        logic                set_status;
        logic [STATUS_W-1:0] status;
        logic                result_load;
    } psem_ctrl_t;

    // status from datapath to controller
    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic             may_wait;
        logic             count_zero;
        logic             count_at_max;
        logic             queue_empty;
        logic             queue_full;
        logic             idx_zero;
        logic             idx_at_end;
        logic             ins_stop;     // entry below idx outranks or ties request
        logic             match;        // entry at idx holds the named task
        logic             out_free;
    } psem_stat_t;

endpackage

// ----- design/psem_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psem_req_if / psem_rsp_if
// Valid/ready channels for semaphore requests and results.
// ----------------------------------------------------------------------------
interface psem_req_if;
    logic                           valid;
    logic                           ready;
    logic [psem_pkg::CMD_W-1:0]     command;
    logic [psem_pkg::TASK_W-1:0]    task_id;
    logic [psem_pkg::PRIO_W-1:0]    priority_req;
    logic                           wait_allowed;

    modport source (output valid, command, task_id, priority_req, wait_allowed,
                    input ready);
    modport sink   (input valid, command, task_id, priority_req, wait_allowed,
                    output ready);
endinterface

interface psem_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [psem_pkg::STATUS_W-1:0]     status;
    logic                              woken_valid;
    logic [psem_pkg::TASK_W-1:0]       woken_task;
    logic                              preempt;
    logic [psem_pkg::COUNT_BITS-1:0]   count_now;
    logic [psem_pkg::WAIT_CNT_W-1:0]   waiters_now;

    modport source (output valid, status, woken_valid, woken_task, preempt,
                    count_now, waiters_now, input ready);
    modport sink   (input valid, status, woken_valid, woken_task, preempt,
                    count_now, waiters_now, output ready);
endinterface

// ----- design/psem_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psem_ctrl
// Sequencer for one semaphore request: dispatch, ordered insert walk,
// search walk, compaction walk and result hand-off.
// ----------------------------------------------------------------------------
module psem_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_ready,
    input  psem_pkg::psem_stat_t   stat,
    output psem_pkg::psem_ctrl_t   ctrl
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_INSERT   = 3'd2;
    localparam logic [2:0] S_SEARCH   = 3'd3;
    localparam logic [2:0] S_SHIFT    = 3'd4;
    localparam logic [2:0] S_FINISH   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign req_ready = (state_reg == S_IDLE);

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and datapath commands
    always_comb
    begin
        state_next    = state_reg;
        ctrl          = '0;
        ctrl.rd_below = (state_reg == S_INSERT);
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    ctrl.load_in = 1'b1;
                    state_next   = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next = S_FINISH;
                ctrl.set_status = 1'b1;
                unique case (stat.command)
                    psem_pkg::CMD_TAKE:
                    begin
                        if (!stat.count_zero)
                        begin
                            ctrl.count_dec = 1'b1;
                            ctrl.status    = psem_pkg::ST_GRANTED;
                        end
                        else if (!stat.may_wait)
                        begin
                            ctrl.status = psem_pkg::ST_WOULD_BLOCK;
                        end
                        else if (stat.queue_full)
                        begin
                            ctrl.status = psem_pkg::ST_QUEUE_FULL;
                        end
                        else
                        begin
                            ctrl.set_status = 1'b0;
                            ctrl.idx_total  = 1'b1;
                            state_next      = S_INSERT;
                        end
                    end
                    psem_pkg::CMD_GIVE:
                    begin
                        if (!stat.queue_empty)
                        begin
                            ctrl.capture_head = 1'b1;
                            ctrl.idx_one      = 1'b1;
                            ctrl.status       = psem_pkg::ST_HANDED_OFF;
                            state_next        = S_SHIFT;
                        end
                        else if (stat.count_at_max)
                        begin
                            ctrl.status = psem_pkg::ST_FULL;
                        end
                        else
                        begin
                            ctrl.count_inc = 1'b1;
                            ctrl.status    = psem_pkg::ST_GRANTED;
                        end
                    end
                    psem_pkg::CMD_REMOVE:
                    begin
                        ctrl.set_status = 1'b0;
                        ctrl.idx_clear  = 1'b1;
                        state_next      = S_SEARCH;
                    end
                    default:
                    begin
                        ctrl.status = psem_pkg::ST_NOT_QUEUED;
                    end
                endcase
            end
            S_INSERT:
            begin
                // walk down from the tail, moving less urgent entries up
                if (stat.idx_zero || stat.ins_stop)
                begin
                    ctrl.wr_new     = 1'b1;
                    ctrl.total_inc  = 1'b1;
                    ctrl.set_status = 1'b1;
                    ctrl.status     = psem_pkg::ST_BLOCKED;
                    state_next      = S_FINISH;
                end
                else
                begin
                    ctrl.wr_up   = 1'b1;
                    ctrl.idx_dec = 1'b1;
                end
            end
            S_SEARCH:
            begin
                if (stat.idx_at_end)
                begin
                    ctrl.set_status = 1'b1;
                    ctrl.status     = psem_pkg::ST_NOT_QUEUED;
                    state_next      = S_FINISH;
                end
                else if (stat.match)
                begin
                    ctrl.idx_inc    = 1'b1;
                    ctrl.set_status = 1'b1;
                    ctrl.status     = psem_pkg::ST_REMOVED;
                    state_next      = S_SHIFT;
                end
                else
                begin
                    ctrl.idx_inc = 1'b1;
                end
            end
            S_SHIFT:
            begin
                // close the gap left by the unlinked entry
                if (stat.idx_at_end)
                begin
                    ctrl.total_dec = 1'b1;
                    state_next     = S_FINISH;
                end
                else
                begin
                    ctrl.wr_down = 1'b1;
                    ctrl.idx_inc = 1'b1;
                end
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    ctrl.result_load = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // walks stay inside the queue
    a_insert_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INSERT) |-> !stat.queue_full)
        else $error("insert walk started on a full queue");

    a_shift_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT) |-> !stat.queue_empty)
        else $error("compaction walk on an empty queue");

    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load_in |=> (state_reg == S_DISPATCH))
        else $error("accepted request not dispatched");

endmodule

// ----- design/psem_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psem_dp
// Semaphore datapath: count, limit, ordered waiter queue with one walking
// index, and the result register.
// ----------------------------------------------------------------------------
module psem_dp (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [psem_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [psem_pkg::COUNT_BITS-1:0]       cfg_wdata,
    input  logic [psem_pkg::CMD_W-1:0]            command,
    input  logic [psem_pkg::TASK_W-1:0]           task_id,
    input  logic [psem_pkg::PRIO_W-1:0]           priority_req,
    input  logic                                  wait_allowed,
    input  psem_pkg::psem_ctrl_t                  ctrl,
    output psem_pkg::psem_stat_t                  stat,
    psem_rsp_if.source                            rsp
);

    localparam int CW = psem_pkg::COUNT_BITS;
    localparam int NW = psem_pkg::WAIT_CNT_W;
    localparam int AW = psem_pkg::IDX_W;

    // control registers
    logic [CW-1:0] limit_reg, limit_next;
    logic [CW-1:0] count_reg, count_next;
    logic [NW-1:0] total_reg, total_next;
    logic          out_valid_reg, out_valid_next;

    // payload registers
    logic [NW-1:0]                   idx_reg;
    logic [psem_pkg::CMD_W-1:0]      cmd_reg;
    logic [psem_pkg::TASK_W-1:0]     task_reg;
    logic [psem_pkg::PRIO_W-1:0]     prio_reg;
    logic                            wait_reg;
    logic [psem_pkg::STATUS_W-1:0]   status_reg;
    logic                            woken_valid_reg;
    logic [psem_pkg::TASK_W-1:0]     woken_task_reg;
    logic                            preempt_reg;
    logic [psem_pkg::STATUS_W-1:0]   out_status_reg;
    logic                            out_woken_valid_reg;
    logic [psem_pkg::TASK_W-1:0]     out_woken_task_reg;
    logic                            out_preempt_reg;
    logic [CW-1:0]                   out_count_reg;
    logic [NW-1:0]                   out_waiters_reg;

    // waiter queue, most urgent at entry 0
    logic [psem_pkg::TASK_W-1:0] waiter_task_reg [psem_pkg::MAX_WAITERS];
    logic [psem_pkg::PRIO_W-1:0] waiter_prio_reg [psem_pkg::MAX_WAITERS];

    logic [NW-1:0]               idx_m1;
    logic [NW-1:0]               rd_sel;
    logic [AW-1:0]               rd_addr;
    logic [AW-1:0]               wr_addr;
    logic [psem_pkg::TASK_W-1:0] rd_task;
    logic [psem_pkg::PRIO_W-1:0] rd_prio;
    logic                        out_free;

    // single read port on the walking index
    assign idx_m1  = idx_reg - NW'(1);
    assign rd_sel  = ctrl.rd_below ? idx_m1 : idx_reg;
    assign rd_addr = rd_sel[AW-1:0];
    assign wr_addr = ctrl.wr_down ? idx_m1[AW-1:0] : idx_reg[AW-1:0];
    assign rd_task = waiter_task_reg[rd_addr];
    assign rd_prio = waiter_prio_reg[rd_addr];

    assign out_free = !out_valid_reg || rsp.ready;

    // status to controller
    always_comb
    begin
        stat.command      = cmd_reg;
        stat.may_wait     = wait_reg;
        stat.count_zero   = (count_reg == '0);
        stat.count_at_max = (count_reg >= limit_reg);
        stat.queue_empty  = (total_reg == '0);
        stat.queue_full   = (total_reg == NW'(psem_pkg::MAX_WAITERS));
        stat.idx_zero     = (idx_reg == '0);
        stat.idx_at_end   = (idx_reg == total_reg);
        stat.ins_stop     = (rd_prio >= prio_reg);
        stat.match        = (rd_task == task_reg);
        stat.out_free     = out_free;
    end

    // count, limit, queue size and output valid
    always_comb
    begin
        limit_next     = limit_reg;
        count_next     = count_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg;
        if (ctrl.count_dec)
        begin
            count_next = count_reg - CW'(1);
        end
        if (ctrl.count_inc)
        begin
            count_next = count_reg + CW'(1);
        end
        if (ctrl.total_inc)
        begin
            total_next = total_reg + NW'(1);
        end
        if (ctrl.total_dec)
        begin
            total_next = total_reg - NW'(1);
        end
        if (cfg_we && (cfg_index == psem_pkg::CFG_LIMIT))
        begin
            limit_next = cfg_wdata;
        end
        if (cfg_we && (cfg_index == psem_pkg::CFG_PRESET))
        begin
            count_next = (cfg_wdata > limit_reg) ? limit_reg : cfg_wdata;
            total_next = '0;
        end
        if (ctrl.result_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= CW'(1);
            count_reg     <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            limit_reg     <= limit_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // walking index
    always_ff @(posedge clk)
    begin
        if (ctrl.idx_clear)
        begin
            idx_reg <= '0;
        end
        else if (ctrl.idx_one)
        begin
            idx_reg <= NW'(1);
        end
        else if (ctrl.idx_total)
        begin
            idx_reg <= total_reg;
        end
        else if (ctrl.idx_inc)
        begin
            idx_reg <= idx_reg + NW'(1);
        end
        else if (ctrl.idx_dec)
        begin
            idx_reg <= idx_m1;
        end
    end

    // queue writes: place, move up or move down
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_new)
        begin
            waiter_task_reg[wr_addr] <= task_reg;
            waiter_prio_reg[wr_addr] <= prio_reg;
        end
        else if (ctrl.wr_up || ctrl.wr_down)
        begin
            waiter_task_reg[wr_addr] <= rd_task;
            waiter_prio_reg[wr_addr] <= rd_prio;
        end
    end

    // request latch and per-request result fields
    always_ff @(posedge clk)
    begin
        if (ctrl.load_in)
        begin
            cmd_reg         <= command;
            task_reg        <= task_id;
            prio_reg        <= priority_req;
            wait_reg        <= wait_allowed;
            woken_valid_reg <= 1'b0;
            woken_task_reg  <= '0;
            preempt_reg     <= 1'b0;
        end
        else if (ctrl.capture_head)
        begin
            woken_valid_reg <= 1'b1;
            woken_task_reg  <= waiter_task_reg[0];
            preempt_reg     <= (waiter_prio_reg[0] > prio_reg);
        end
        if (ctrl.set_status)
        begin
            status_reg <= ctrl.status;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (ctrl.result_load)
        begin
            out_status_reg      <= status_reg;
            out_woken_valid_reg <= woken_valid_reg;
            out_woken_task_reg  <= woken_task_reg;
            out_preempt_reg     <= preempt_reg;
            out_count_reg       <= count_reg;
            out_waiters_reg     <= total_reg;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.woken_valid = out_woken_valid_reg;
    assign rsp.woken_task  = out_woken_task_reg;
    assign rsp.preempt     = out_preempt_reg;
    assign rsp.count_now   = out_count_reg;
    assign rsp.waiters_now = out_waiters_reg;

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= NW'(psem_pkg::MAX_WAITERS))
        else $error("waiter total above queue depth");

    a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_we |=> (total_reg == $past(total_reg))
                 || (total_reg == $past(total_reg) + NW'(1))
                 || (total_reg == $past(total_reg) - NW'(1)))
        else $error("waiter total moved by more than one");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.result_load |-> out_free)
        else $error("result overwritten before transfer");

    a_woken_handoff: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_woken_valid_reg)
            |-> (out_status_reg == psem_pkg::ST_HANDED_OFF))
        else $error("woken task reported without hand-off");

endmodule

// ----- design/priority_wait_counting_semaphore_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_wait_counting_semaphore_top
// Counting semaphore with a priority-ordered waiter queue.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one command per transfer: take, give or remove waiter, with
//   task id, priority and a blocking flag. rsp returns exactly one result per
//   request: status, released waiter (for a give), count and queue size.
//   cfg_we/cfg_index/cfg_wdata write the count limit (index 0) or the preset
//   count (index 1); writing the preset loads the saturated count and empties
//   the queue. Write configuration only while no request is in flight.
// Sequencing:
//   one request at a time. A plain count update passes through accept,
//   dispatch and result load. Each step of a queue walk handles one entry:
//   an ordered insert moves up to MAX_WAITERS - 1 entries from the tail and
//   then places, a remove searches from the head and then compacts, a
//   hand-off compacts the whole queue. The worst case is a remove on a full
//   queue. The queue read port on the walking index sets this step size.
//   A new request is taken while an earlier result still waits in rsp.
// Reset: count 0, limit 1, queue empty, no result pending.
// Stall: a held result blocks only the completion of the next request.
// ----------------------------------------------------------------------------
module priority_wait_counting_semaphore_top (
    input  logic                              clk,
    input  logic                              rst_n,
    psem_req_if.sink                          req,
    psem_rsp_if.source                        rsp,
    input  logic                              cfg_we,
    input  logic [psem_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [psem_pkg::COUNT_BITS-1:0]   cfg_wdata
);

    psem_pkg::psem_ctrl_t ctrl;
    psem_pkg::psem_stat_t stat;

    // sequencer
    psem_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    // count, queue and result register
    psem_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .command      (req.command),
        .task_id      (req.task_id),
        .priority_req (req.priority_req),
        .wait_allowed (req.wait_allowed),
        .ctrl         (ctrl),
        .stat         (stat),
        .rsp          (rsp)
    );

endmodule
